// ----- sv/calrec_pkg.sv -----
// Package for the calibration record checker and builder.
// Holds record constants, status codes, result type and the word-wide CRC-32 step.
// No dependencies.
package calrec_pkg;

  localparam logic [31:0] REC_MAGIC   = 32'hCA1B_F0C1;
  localparam logic [15:0] REC_VERSION = 16'h0001;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0] WORD_ONES   = 32'hFFFF_FFFF;

  // Word positions within a record.
  localparam logic [2:0] POS_MAGIC   = 3'd0;
  localparam logic [2:0] POS_VERSION = 3'd1;
  localparam logic [2:0] POS_ANGLE   = 3'd2;
  localparam logic [2:0] POS_POLES   = 3'd3;
  localparam logic [2:0] POS_DIR     = 3'd4;
  localparam logic [2:0] POS_CRC     = 3'd5;

  // Fault flag bit positions.
  localparam int FLAG_EMPTY = 0;
  localparam int FLAG_HDR   = 1;
  localparam int FLAG_POLES = 2;
  localparam int FLAG_DIR   = 3;

  // Request kinds.
  localparam logic REQ_CHECK = 1'b0;
  localparam logic REQ_BUILD = 1'b1;

  // Configuration register index (byte address bit 2).
  typedef enum logic {
    REG_POLES   = 1'b0,
    REG_ENC_DIR = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_VALID   = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_BAD_HDR = 3'd2,
    ST_CRC     = 3'd3,
    ST_POLES   = 3'd4,
    ST_DIR     = 3'd5
  } status_t;

  // One result word as it travels to the output register.
  typedef struct packed {
    logic [31:0] word;
    status_t     status;
    logic        last;
  } res_t;

  typedef logic [31:0][31:0] crc_mat_t;

  // Thirty-two bit-serial CRC steps; only used to build the constant matrix.
  function automatic logic [31:0] crc_shift32(input logic [31:0] c);
    logic [31:0] v;
    v = c;
    for (int k = 0; k < 32; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  // Row j holds the input bits that feed output bit j after one word step.
  function automatic crc_mat_t crc_matrix();
    crc_mat_t    m;
    logic [31:0] col;
    m = '0;
    for (int i = 0; i < 32; i++) begin
      col = crc_shift32(32'(1) << i);
      for (int j = 0; j < 32; j++) begin
        m[j][i] = col[j];
      end
    end
    return m;
  endfunction

  localparam crc_mat_t CRC_MAT = crc_matrix();

  // One whole-word CRC step as a single XOR network.
  function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [31:0] w);
    logic [31:0] c;
    logic [31:0] r;
    c = acc ^ w;
    for (int j = 0; j < 32; j++) begin
      r[j] = ^(c & CRC_MAT[j]);
    end
    return r;
  endfunction

  function automatic logic [31:0] dir_word(input logic [1:0] d);
    return {{30{d[1]}}, d};
  endfunction

  function automatic logic [31:0] poles_word(input logic [7:0] p);
    return {24'd0, p};
  endfunction

endpackage

// ----- sv/calrec_in_if.sv -----
// Request channel interface of the calibration record block.
// Carries valid, ready and one request; no dependencies.
interface calrec_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] rec_word;
  logic        first_word;

  modport source(output valid, req_type, rec_word, first_word, input ready);
  modport sink(input valid, req_type, rec_word, first_word, output ready);
endinterface

// ----- sv/calrec_out_if.sv -----
// Result channel interface of the calibration record block.
// Carries valid, ready and one result word; no dependencies.
interface calrec_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic [2:0]  status;
  logic        last;

  modport source(output valid, out_word, status, last, input ready);
  modport sink(input valid, out_word, status, last, output ready);
endinterface

// ----- sv/calrec_cfg.sv -----
// APB-style configuration registers: expected pole pairs and encoder direction.
// Depends on calrec_pkg.
module calrec_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  pole_cnt,
  output logic [1:0]  enc_dir
);

  logic [7:0] poles_r;
  logic [1:0] dir_r;
  logic       wr_en;
  calrec_pkg::cfg_reg_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = calrec_pkg::cfg_reg_t'(paddr[2]);

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poles_r <= 8'd7;
      dir_r   <= 2'd1;
    end else if (wr_en) begin
      unique case (sel)
        calrec_pkg::REG_POLES:   poles_r <= pwdata[7:0];
        calrec_pkg::REG_ENC_DIR: dir_r   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (sel)
      calrec_pkg::REG_POLES:   prdata = {24'd0, poles_r};
      calrec_pkg::REG_ENC_DIR: prdata = {30'd0, dir_r};
      default:                 prdata = '0;
    endcase
  end

  assign pole_cnt = poles_r;
  assign enc_dir  = dir_r;

endmodule

// ----- sv/calrec_check.sv -----
// Record check unit: word position, running CRC, fault flags and held angle.
// Depends on calrec_pkg.
module calrec_check (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [31:0]       word,
  input  logic              first,
  input  logic [7:0]        pole_cnt,
  input  logic [1:0]        enc_dir,
  output logic              has_res,
  output calrec_pkg::res_t  res
);

  logic [2:0]  pos_r,   pos_nxt;
  logic [31:0] acc_r,   acc_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [31:0] angle_r, angle_nxt;

  logic        restart;
  logic [2:0]  pos_eff;
  logic [31:0] acc_eff;
  logic [3:0]  flags_eff;
  logic [31:0] angle_eff;
  calrec_pkg::status_t st;

  // A flagged first word, an idle position or a bad position starts over.
  assign restart   = first || (pos_r == calrec_pkg::POS_MAGIC) || (pos_r > calrec_pkg::POS_CRC);
  assign pos_eff   = restart ? calrec_pkg::POS_MAGIC : pos_r;
  assign acc_eff   = restart ? calrec_pkg::CRC_INIT : acc_r;
  assign flags_eff = restart ? 4'd0 : flags_r;
  assign angle_eff = restart ? 32'd0 : angle_r;
  assign has_res   = (pos_eff == calrec_pkg::POS_CRC);

  // Status follows the fixed fault priority.
  always_comb begin
    priority if (flags_eff[calrec_pkg::FLAG_EMPTY])  st = calrec_pkg::ST_EMPTY;
    else if (flags_eff[calrec_pkg::FLAG_HDR])        st = calrec_pkg::ST_BAD_HDR;
    else if (~acc_eff != word)                       st = calrec_pkg::ST_CRC;
    else if (flags_eff[calrec_pkg::FLAG_POLES])      st = calrec_pkg::ST_POLES;
    else if (flags_eff[calrec_pkg::FLAG_DIR])        st = calrec_pkg::ST_DIR;
    else                                             st = calrec_pkg::ST_VALID;
  end

  always_comb begin
    res.word   = (st == calrec_pkg::ST_VALID) ? angle_eff : 32'd0;
    res.status = st;
    res.last   = 1'b1;
  end

  // Next state for one accepted check word.
  always_comb begin
    acc_nxt   = acc_eff;
    flags_nxt = flags_eff;
    angle_nxt = angle_eff;
    pos_nxt   = pos_eff + 3'd1;
    if (pos_eff < calrec_pkg::POS_CRC) begin
      acc_nxt = calrec_pkg::crc_step(acc_eff, word);
    end
    unique case (pos_eff)
      calrec_pkg::POS_MAGIC: begin
        if (word == 32'd0 || word == calrec_pkg::WORD_ONES) begin
          flags_nxt[calrec_pkg::FLAG_EMPTY] = 1'b1;
        end
        if (word != calrec_pkg::REC_MAGIC) begin
          flags_nxt[calrec_pkg::FLAG_HDR] = 1'b1;
        end
      end
      calrec_pkg::POS_VERSION: begin
        if (word[15:0] != calrec_pkg::REC_VERSION) begin
          flags_nxt[calrec_pkg::FLAG_HDR] = 1'b1;
        end
      end
      calrec_pkg::POS_ANGLE: angle_nxt = word;
      calrec_pkg::POS_POLES: begin
        if (word != calrec_pkg::poles_word(pole_cnt)) begin
          flags_nxt[calrec_pkg::FLAG_POLES] = 1'b1;
        end
      end
      calrec_pkg::POS_DIR: begin
        if (word != calrec_pkg::dir_word(enc_dir)) begin
          flags_nxt[calrec_pkg::FLAG_DIR] = 1'b1;
        end
      end
      default: begin
        pos_nxt   = calrec_pkg::POS_MAGIC;
        acc_nxt   = calrec_pkg::CRC_INIT;
        flags_nxt = 4'd0;
        angle_nxt = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= calrec_pkg::POS_MAGIC;
      acc_r   <= calrec_pkg::CRC_INIT;
      flags_r <= 4'd0;
      angle_r <= 32'd0;
    end else if (step) begin
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      flags_r <= flags_nxt;
      angle_r <= angle_nxt;
    end
  end

endmodule

// ----- sv/calrec_build.sv -----
// Record build sequencer: emits the six record words, folding the CRC as it goes.
// Depends on calrec_pkg.
module calrec_build (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [31:0]       angle,
  input  logic [7:0]        pole_cnt,
  input  logic [1:0]        enc_dir,
  output logic              done,
  output calrec_pkg::res_t  res
);

  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] crc_in;
  logic [31:0] word;

  assign crc_in = (cnt_r == calrec_pkg::POS_MAGIC) ? calrec_pkg::CRC_INIT : crc_r;
  assign done   = (cnt_r == calrec_pkg::POS_CRC);

  // Word for the current position.
  always_comb begin
    unique case (cnt_r)
      calrec_pkg::POS_MAGIC:   word = calrec_pkg::REC_MAGIC;
      calrec_pkg::POS_VERSION: word = {16'd0, calrec_pkg::REC_VERSION};
      calrec_pkg::POS_ANGLE:   word = angle;
      calrec_pkg::POS_POLES:   word = calrec_pkg::poles_word(pole_cnt);
      calrec_pkg::POS_DIR:     word = calrec_pkg::dir_word(enc_dir);
      default:                 word = ~crc_in;
    endcase
  end

  always_comb begin
    res.word   = word;
    res.status = calrec_pkg::ST_VALID;
    res.last   = done;
  end

  // Advance one word each time the output takes one.
  always_comb begin
    cnt_nxt = done ? calrec_pkg::POS_MAGIC : cnt_r + 3'd1;
    crc_nxt = calrec_pkg::crc_step(crc_in, word);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= calrec_pkg::POS_MAGIC;
    end else if (go) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      crc_r <= crc_nxt;
    end
  end

endmodule

// ----- sv/calrec_record_crc_check_placeholder.sv -----
// Output holding register between the record units and the result channel.
// Depends on calrec_pkg.
module calrec_outreg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  calrec_pkg::res_t  res_in,
  input  logic              ready,
  output logic              valid,
  output calrec_pkg::res_t  res_out,
  output logic              free
);

  logic             valid_r, valid_nxt;
  calrec_pkg::res_t res_r;

  assign free = !valid_r || ready;

  always_comb begin
    priority if (load) valid_nxt = 1'b1;
    else if (ready)    valid_nxt = 1'b0;
    else               valid_nxt = valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid   = valid_r;
  assign res_out = res_r;

endmodule

// ----- sv/calib_record_crc_check.sv -----
// Calibration record checker and builder, top level.
// A request is registered in the input stage, then its result lands in the output register.
// Throughput: one check word per cycle while a record's last word finds the output register free;
// a build request holds the input stage until its six record words pass the single output register.
// Reset (rst_n, synchronous): check restarts at word 0, CRC all ones, registers 7 and 1.
module calib_record_crc_check (
  input  logic        clk,
  input  logic        rst_n,
  calrec_in_if.sink   in_ch,
  calrec_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        a_valid_r;
  logic        a_req_r;
  logic [31:0] a_word_r;
  logic        a_first_r;
  logic        a_adv;

  logic [7:0]  pole_cnt;
  logic [1:0]  enc_dir;

  logic             chk_step, chk_has_res;
  logic             bld_go, bld_done;
  logic             out_free, out_load;
  calrec_pkg::res_t chk_res, bld_res, sel_res, o_res;

  calrec_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .pole_cnt   (pole_cnt),
    .enc_dir    (enc_dir)
  );

  // Input request register; it moves on once its results are placed.
  assign in_ch.ready = !a_valid_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      a_req_r   <= in_ch.req_type;
      a_word_r  <= in_ch.rec_word;
      a_first_r <= in_ch.first_word;
    end
  end

  // Check words without a result always move; others wait for the output slot.
  always_comb begin
    if (a_req_r == calrec_pkg::REQ_BUILD) begin
      a_adv = a_valid_r && out_free && bld_done;
    end else begin
      a_adv = a_valid_r && (!chk_has_res || out_free);
    end
  end

  assign chk_step = a_valid_r && (a_req_r == calrec_pkg::REQ_CHECK) && a_adv;
  assign bld_go   = a_valid_r && (a_req_r == calrec_pkg::REQ_BUILD) && out_free;
  assign out_load = (chk_step && chk_has_res) || bld_go;
  assign sel_res  = (a_req_r == calrec_pkg::REQ_BUILD) ? bld_res : chk_res;

  calrec_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (chk_step),
    .word       (a_word_r),
    .first      (a_first_r),
    .pole_cnt   (pole_cnt),
    .enc_dir    (enc_dir),
    .has_res    (chk_has_res),
    .res        (chk_res)
  );

  calrec_build u_build (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (bld_go),
    .angle      (a_word_r),
    .pole_cnt   (pole_cnt),
    .enc_dir    (enc_dir),
    .done       (bld_done),
    .res        (bld_res)
  );

  calrec_outreg u_outreg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (out_load),
    .res_in  (sel_res),
    .ready   (out_ch.ready),
    .valid   (out_ch.valid),
    .res_out (o_res),
    .free    (out_free)
  );

  assign out_ch.out_word = o_res.word;
  assign out_ch.status   = o_res.status;
  assign out_ch.last     = o_res.last;

  // A failed check never reports an angle.
  a_fail_no_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != calrec_pkg::ST_VALID) |-> out_ch.out_word == 32'd0)
    else $error("failed check carries a nonzero angle word");

  // Only build words come out without last, and they always carry valid status.
  a_mid_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last |-> out_ch.status == calrec_pkg::ST_VALID)
    else $error("intermediate result with a fault status");

  // A held request is not overwritten.
  a_hold_req: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !a_adv |=> a_valid_r && $stable(a_word_r) && $stable(a_req_r))
    else $error("input stage changed while its request was pending");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for calib_record_crc_check: directed and random record checks and builds.
// Depends on calrec_pkg, calrec_in_if, calrec_out_if and the block itself.
module tb_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 80;
  localparam int IDLE_PCT     = 34;

  // One row of the directed stimulus table.
  typedef struct {
    logic                req;
    logic [31:0]         word;
    logic                first;
    bit                  crc_fill;
    bit                  has_result;
    logic [31:0]         t_word;
    calrec_pkg::status_t t_status;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  logic steady;
  int   accepted_count = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;

  // Predictor state: configuration and the record being checked.
  logic [7:0]       poles_cfg;
  logic [1:0]       enc_dir_cfg;
  logic [2:0]       rec_pos;
  logic [31:0]      rec_crc;
  logic [3:0]       rec_faults;
  logic [31:0]      rec_angle;
  calrec_pkg::res_t pending_record_words[$];

  calrec_in_if  in_if();
  calrec_out_if out_if();

  calib_record_crc_check DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Directed rows run under the reset configuration (7 pole pairs, direction 1).
  dir_row_t directed_rows [23] = '{
    // Builds with extreme angles; first_word is ignored.
    '{calrec_pkg::REQ_BUILD, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'h0, calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_BUILD, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0, calrec_pkg::ST_VALID},
    // Valid record without first_word, reserved version bits set, a build in between.
    '{calrec_pkg::REQ_CHECK, calrec_pkg::REC_MAGIC, 1'b0, 1'b0, 1'b0, 32'h0,
      calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_CHECK, 32'hFFFF_0001, 1'b0, 1'b0, 1'b0, 32'h0, calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_CHECK, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0, calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_BUILD, 32'h1234_5678, 1'b1, 1'b0, 1'b0, 32'h0, calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_CHECK, 32'h0000_0007, 1'b0, 1'b0, 1'b0, 32'h0, calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_CHECK, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 32'h0, calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_CHECK, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF,
      calrec_pkg::ST_VALID},
    // Partial record dropped by a restart on an empty magic word.
    '{calrec_pkg::REQ_CHECK, calrec_pkg::REC_MAGIC, 1'b1, 1'b0, 1'b0, 32'h0,
      calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_CHECK, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 32'h0, calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_CHECK, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'h0, calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_CHECK, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 32'h0, calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_CHECK, 32'hA5A5_A5A5, 1'b0, 1'b0, 1'b0, 32'h0, calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_CHECK, 32'h0000_0007, 1'b0, 1'b0, 1'b0, 32'h0, calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_CHECK, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 32'h0, calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_CHECK, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'h0, calrec_pkg::ST_EMPTY},
    // A bad CRC outranks a pole mismatch.
    '{calrec_pkg::REQ_CHECK, calrec_pkg::REC_MAGIC, 1'b1, 1'b0, 1'b0, 32'h0,
      calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_CHECK, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 32'h0, calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_CHECK, 32'h5A5A_5A5A, 1'b0, 1'b0, 1'b0, 32'h0, calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_CHECK, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0, calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_CHECK, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 32'h0, calrec_pkg::ST_VALID},
    '{calrec_pkg::REQ_CHECK, 32'h0000_0000, 1'b0, 1'b0, 1'b1, 32'h0, calrec_pkg::ST_CRC}
  };

  always #5 clk = ~clk;

  // Run length guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** calib_record_crc_check: FAILED **");
      $finish;
    end
  end

  // Result side stalls at random, except during the steady stretch.
  always @(posedge clk) begin
    out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    calrec_pkg::res_t exp_res;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_record_words.size() == 0) begin
        $display("%0t: unexpected result, expected none actual word %08h status %0d last %0b",
                 $time, out_if.out_word, out_if.status, out_if.last);
        mismatch_count++;
      end else begin
        exp_res = pending_record_words.pop_front();
        if (out_if.out_word !== exp_res.word) begin
          $display("%0t: out_word mismatch, expected %08h actual %08h",
                   $time, exp_res.word, out_if.out_word);
          mismatch_count++;
        end
        if (out_if.status !== exp_res.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, exp_res.status, out_if.status);
          mismatch_count++;
        end
        if (out_if.last !== exp_res.last) begin
          $display("%0t: last mismatch, expected %0b actual %0b",
                   $time, exp_res.last, out_if.last);
          mismatch_count++;
        end
      end
    end
  end

  // Reflected CRC-32, one whole word per call.
  function automatic logic [31:0] crc_word(input logic [31:0] acc, input logic [31:0] w);
    logic [31:0] c;
    int k;
    c = acc ^ w;
    for (k = 0; k < 32; k++) begin
      c = c[0] ? ((c >> 1) ^ calrec_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] pole_field();
    return {24'd0, poles_cfg};
  endfunction

  function automatic logic [31:0] dir_field();
    return {{30{enc_dir_cfg[1]}}, enc_dir_cfg};
  endfunction

  function automatic void clear_record();
    rec_pos    = calrec_pkg::POS_MAGIC;
    rec_crc    = calrec_pkg::CRC_INIT;
    rec_faults = '0;
    rec_angle  = '0;
  endfunction

  // Expected results of one accepted request; updates the check state.
  function automatic void compute_record_results(input logic req, input logic [31:0] w,
                                                 input logic first);
    logic [31:0]         built [6];
    logic [31:0]         c;
    calrec_pkg::status_t st;
    calrec_pkg::res_t    r;
    int                  i;
    if (req == calrec_pkg::REQ_BUILD) begin
      built[0] = calrec_pkg::REC_MAGIC;
      built[1] = {16'd0, calrec_pkg::REC_VERSION};
      built[2] = w;
      built[3] = pole_field();
      built[4] = dir_field();
      c = calrec_pkg::CRC_INIT;
      for (i = 0; i < 5; i++) begin
        c = crc_word(c, built[i]);
      end
      built[5] = ~c;
      for (i = 0; i < 6; i++) begin
        r.word   = built[i];
        r.status = calrec_pkg::ST_VALID;
        r.last   = (i == 5);
        pending_record_words.push_back(r);
      end
      return;
    end

    if (first || rec_pos == calrec_pkg::POS_MAGIC || rec_pos > calrec_pkg::POS_CRC) begin
      clear_record();
    end
    if (rec_pos < calrec_pkg::POS_CRC) rec_crc = crc_word(rec_crc, w);

    case (rec_pos)
      calrec_pkg::POS_MAGIC: begin
        if (w == 32'd0 || w == calrec_pkg::WORD_ONES) begin
          rec_faults[calrec_pkg::FLAG_EMPTY] = 1'b1;
        end
        if (w != calrec_pkg::REC_MAGIC) rec_faults[calrec_pkg::FLAG_HDR] = 1'b1;
      end
      calrec_pkg::POS_VERSION: begin
        if (w[15:0] != calrec_pkg::REC_VERSION) rec_faults[calrec_pkg::FLAG_HDR] = 1'b1;
      end
      calrec_pkg::POS_ANGLE: rec_angle = w;
      calrec_pkg::POS_POLES: begin
        if (w != pole_field()) rec_faults[calrec_pkg::FLAG_POLES] = 1'b1;
      end
      calrec_pkg::POS_DIR: begin
        if (w != dir_field()) rec_faults[calrec_pkg::FLAG_DIR] = 1'b1;
      end
      default: begin
        // Fault priority: empty, header, CRC, poles, direction.
        if (rec_faults[calrec_pkg::FLAG_EMPTY])      st = calrec_pkg::ST_EMPTY;
        else if (rec_faults[calrec_pkg::FLAG_HDR])   st = calrec_pkg::ST_BAD_HDR;
        else if (~rec_crc != w)                      st = calrec_pkg::ST_CRC;
        else if (rec_faults[calrec_pkg::FLAG_POLES]) st = calrec_pkg::ST_POLES;
        else if (rec_faults[calrec_pkg::FLAG_DIR])   st = calrec_pkg::ST_DIR;
        else                                         st = calrec_pkg::ST_VALID;
        r.word   = (st == calrec_pkg::ST_VALID) ? rec_angle : 32'd0;
        r.status = st;
        r.last   = 1'b1;
        pending_record_words.push_back(r);
        clear_record();
        return;
      end
    endcase
    rec_pos++;
  endfunction

  // Offer one request, idling at random first; returns at the accepting edge.
  task automatic send_request(input logic req, input logic [31:0] w, input logic first);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.req_type   <= req;
    in_if.rec_word   <= w;
    in_if.first_word <= first;
    do @(posedge clk); while (!in_if.ready);
    accepted_count++;
    compute_record_results(req, w, first);
  endtask

  // A word that often trips the checks: zero, all ones or random.
  function automatic logic [31:0] odd_word();
    case ($urandom_range(3))
      0:       return 32'd0;
      1:       return calrec_pkg::WORD_ONES;
      default: return $urandom;
    endcase
  endfunction

  // Well-formed record with rare faults; fewer than six words leaves it broken.
  task automatic send_record(input int words_to_send);
    logic [31:0] w;
    logic [1:0]  d;
    bit          bad;
    int          i;
    for (i = 0; i < words_to_send; i++) begin
      bad = ($urandom_range(99) < 6);
      d   = 2'($urandom);
      case (i)
        0: w = bad ? odd_word() : calrec_pkg::REC_MAGIC;
        1: w = bad ? odd_word() : {($urandom_range(1) ? 16'($urandom) : 16'h0),
                                   calrec_pkg::REC_VERSION};
        2: w = ($urandom_range(9) == 0) ? odd_word() : $urandom;
        3: w = bad ? ($urandom_range(1) ? odd_word() : {24'd0, 8'($urandom)}) : pole_field();
        4: w = bad ? ($urandom_range(1) ? odd_word() : {{30{d[1]}}, d}) : dir_field();
        default: w = bad ? odd_word() : ~rec_crc;
      endcase
      send_request(calrec_pkg::REQ_CHECK, w, (i == 0) ? ($urandom_range(4) != 0) : 1'b0);
      // A build in the middle must leave the check alone.
      if (i < 5 && $urandom_range(99) < 4) begin
        send_request(calrec_pkg::REQ_BUILD, $urandom, 1'($urandom_range(1)));
      end
    end
  endtask

  // Wait until every expected result has come and the pipeline is empty.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_record_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write in a setup and an access phase; the predictor follows at the access edge.
  task automatic write_register(input calrec_pkg::cfg_reg_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      calrec_pkg::REG_POLES:   poles_cfg   = value[7:0];
      calrec_pkg::REG_ENC_DIR: enc_dir_cfg = value[1:0];
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Reset, directed table, then random phases under changing registers.
  initial begin
    dir_row_t         row;
    calrec_pkg::res_t typed_result;
    int               phase;
    int               phase_start;
    int               pick;
    int               i;

    rst_n            <= 1'b0;
    steady           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.req_type   <= calrec_pkg::REQ_CHECK;
    in_if.rec_word   <= 32'd0;
    in_if.first_word <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    poles_cfg        = 8'd7;
    enc_dir_cfg      = 2'd1;
    clear_record();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < $size(directed_rows); i++) begin
      row = directed_rows[i];
      send_request(row.req, row.crc_fill ? ~rec_crc : row.word, row.first);
      if (row.has_result) begin
        typed_result.word   = row.t_word;
        typed_result.status = row.t_status;
        typed_result.last   = 1'b1;
        pending_record_words[pending_record_words.size() - 1] = typed_result;
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        wait_drained();
        case (phase)
          1: begin
            write_register(calrec_pkg::REG_POLES, 32'd1);
            write_register(calrec_pkg::REG_ENC_DIR, 32'hFFFF_FFFF);
          end
          2: begin
            write_register(calrec_pkg::REG_POLES, 32'd255);
            write_register(calrec_pkg::REG_ENC_DIR, 32'd0);
          end
          3: begin
            // Direction pattern 2'b10 sign-extends to -2.
            write_register(calrec_pkg::REG_POLES, 32'($urandom_range(2, 254)));
            write_register(calrec_pkg::REG_ENC_DIR, 32'd2);
          end
          default: begin
            write_register(calrec_pkg::REG_POLES, 32'($urandom_range(1, 255)));
            write_register(calrec_pkg::REG_ENC_DIR, 32'($urandom_range(2)) - 32'd1);
          end
        endcase
      end
      // Phase 2 runs with no idling on either side.
      steady <= (phase == 2);
      phase_start = accepted_count;
      while (accepted_count - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          send_record(6);
        end else if (pick < 75) begin
          send_request(calrec_pkg::REQ_BUILD, odd_word(), 1'($urandom_range(1)));
        end else if (pick < 88) begin
          send_record($urandom_range(1, 5));
        end else begin
          send_request(calrec_pkg::REQ_CHECK, $urandom, 1'($urandom_range(1)));
        end
      end
    end

    wait_drained();
    if (mismatch_count == 0 && pending_record_words.size() == 0) begin
      $display("** calib_record_crc_check: PASSED **");
    end else begin
      $display("** calib_record_crc_check: FAILED **");
    end
    $finish;
  end

endmodule
